// ----- design/gtoi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtoi_pkg
// Shared types and constants for the gyro temperature offset interpolator.
// ----------------------------------------------------------------------------
package gtoi_pkg;

    // table geometry
    localparam int DEF_NUM_ENTRIES = 16;
    // temperature counts between neighboring entries, a power of two
    localparam int TEMP_STEP = 256;
    localparam int STEP_W    = $clog2(TEMP_STEP);

    // data widths
    localparam int DATA_W    = 16;
    localparam int IDX_W     = DATA_W + 1;   // exact temperature minus origin
    localparam int RATE_W    = 10;
    localparam int RATE_SHIFT = 6;
    localparam int ENTRY_IDX_W = 4;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_X   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_Y   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_Z   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING_Z   = 3'd6;

    // command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    typedef logic signed [DATA_W-1:0] axis_t;

    // configuration register file contents
    typedef struct packed {
        axis_t temp_base;
        axis_t residual_x;
        axis_t residual_y;
        axis_t residual_z;
        axis_t coupling_x;
        axis_t coupling_y;
        axis_t coupling_z;
    } cfg_regs_t;

endpackage

// ----- design/gtoi_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtoi_cfg_regs
// Configuration register file: origin, residual and coupling per axis.
// ----------------------------------------------------------------------------
module gtoi_cfg_regs
    import gtoi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output cfg_regs_t            cfg
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    // decode one register write per word
    always_comb begin
        regs_next = regs_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_TEMP_BASE:    regs_next.temp_base    = cfg_data;
                REG_RESIDUAL_X:   regs_next.residual_x   = cfg_data;
                REG_RESIDUAL_Y:   regs_next.residual_y   = cfg_data;
                REG_RESIDUAL_Z:   regs_next.residual_z   = cfg_data;
                REG_COUPLING_X:   regs_next.coupling_x   = cfg_data;
                REG_COUPLING_Y:   regs_next.coupling_y   = cfg_data;
                REG_COUPLING_Z:   regs_next.coupling_z   = cfg_data;
                default:          regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= '0;
        end else begin
            regs_reg <= regs_next;
        end
    end

    assign cfg = regs_reg;

endmodule

// ----- design/gtoi_offset_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtoi_offset_table
// Offset table memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module gtoi_offset_table
    import gtoi_pkg::*;
#(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
    parameter int ADDR_W      = $clog2(NUM_ENTRIES)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [3*DATA_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr_a,
    input  logic [ADDR_W-1:0]   rd_addr_b,
    output logic [3*DATA_W-1:0] rd_data_a,
    output logic [3*DATA_W-1:0] rd_data_b
);

    logic [3*DATA_W-1:0] mem [NUM_ENTRIES];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read ports, data held while the pipeline stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ----- design/gtoi_interp_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtoi_interp_axis
// One axis of the interpolation: left + (right - left) * frac / step,
// plus residual and optional coupling, with the rate-scaled copy.
// ----------------------------------------------------------------------------
module gtoi_interp_axis
    import gtoi_pkg::*;
(
    input  axis_t                    left_val,
    input  axis_t                    right_val,
    input  logic [STEP_W-1:0]        frac,
    input  logic                     interp,
    input  axis_t                    residual,
    input  axis_t                    coupling,
    output logic [DATA_W-1:0]        offset,
    output logic [RATE_W-1:0]        rate_offset
);

    localparam int PROD_W = IDX_W + STEP_W + 1;

    logic signed [IDX_W-1:0]  diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] quot;
    logic [DATA_W-1:0]        coup_term;

    // exact entry difference times fraction
    assign diff = IDX_W'(right_val) - IDX_W'(left_val);
    assign prod = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));

    // divide by step, truncating toward zero
    assign biased = prod[PROD_W-1] ? prod + PROD_W'(TEMP_STEP - 1) : prod;
    assign quot   = biased >>> STEP_W;

    // wrapping 16-bit sum
    assign coup_term   = interp ? DATA_W'(coupling) : '0;
    assign offset      = DATA_W'(left_val) + quot[DATA_W-1:0]
                         + DATA_W'(residual) + coup_term;
    assign rate_offset = offset[DATA_W-1:RATE_SHIFT];

endmodule

// ----- design/gyro_temp_offset_interp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_temp_offset_interp_core
// Temperature-compensated three-axis gyro offset with table interpolation.
// ----------------------------------------------------------------------------
//  channel   dir   handshake               payload
//  s_        in    s_valid / s_ready       cmd, temperature, entry index, x/y/z
//  m_        out   m_valid / m_ready       offsets, rate offsets, clamp flags
//  cfg_      in    cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  One word per cycle in while s_ready is high; the table read register loads
//  at the accepting edge and the result register loads from it once the result
//  register is free, raising m_valid. Write commands give no result.
//  Reset clears the pipeline valids and the configuration registers; the
//  offset table is not cleared. When m_ready is low the result register holds,
//  the read stage may still fill once, then s_ready drops. cfg_ready is high.
// ----------------------------------------------------------------------------
module gyro_temp_offset_interp_core
    import gtoi_pkg::*;
#(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_cmd,
    input  logic signed [DATA_W-1:0] s_temperature,
    input  logic [ENTRY_IDX_W-1:0]  s_entry_index,
    input  logic signed [DATA_W-1:0] s_entry_x,
    input  logic signed [DATA_W-1:0] s_entry_y,
    input  logic signed [DATA_W-1:0] s_entry_z,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [DATA_W-1:0] m_offset_x,
    output logic signed [DATA_W-1:0] m_offset_y,
    output logic signed [DATA_W-1:0] m_offset_z,
    output logic signed [RATE_W-1:0] m_rate_offset_x,
    output logic signed [RATE_W-1:0] m_rate_offset_y,
    output logic signed [RATE_W-1:0] m_rate_offset_z,
    output logic                    m_clamped_low,
    output logic                    m_clamped_high,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DATA_W-1:0]       cfg_data
);

    localparam int ADDR_W = $clog2(NUM_ENTRIES);
    localparam int WIDE_W = 32;

    cfg_regs_t cfg;

    // handshake
    logic s_fire;
    logic lookup_fire;
    logic out_free;

    // lookup address calculation
    logic signed [IDX_W-1:0] idx;
    logic                    low;
    logic                    high;
    logic [WIDE_W-1:0]       msb_ext;
    logic [STEP_W-1:0]       frac;
    logic [ADDR_W-1:0]       addr_a;
    logic [ADDR_W-1:0]       addr_b;

    // table write decode
    logic [WIDE_W-1:0]       wr_idx_ext;
    logic                    wr_en;

    // read stage
    logic                    s1_vld_reg;
    logic                    s1_low_reg;
    logic                    s1_high_reg;
    logic [STEP_W-1:0]       s1_frac_reg;
    logic [3*DATA_W-1:0]     rd_a;
    logic [3*DATA_W-1:0]     rd_b;
    logic                    s1_interp;

    // result stage
    logic [DATA_W-1:0]       off_x, off_y, off_z;
    logic [RATE_W-1:0]       rate_x, rate_y, rate_z;
    logic                    m_valid_reg;
    logic [DATA_W-1:0]       off_x_reg, off_y_reg, off_z_reg;
    logic [RATE_W-1:0]       rate_x_reg, rate_y_reg, rate_z_reg;
    logic                    low_reg, high_reg;

    assign cfg_ready = 1'b1;

    gtoi_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // pipeline flow control
    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = !s1_vld_reg || out_free;
    assign s_fire      = s_valid && s_ready;
    assign lookup_fire = s_fire && (s_cmd == CMD_LOOKUP);

    // index into the table and clamp decisions
    assign idx     = IDX_W'(s_temperature) - IDX_W'(cfg.temp_base);
    assign low     = idx[IDX_W-1];
    assign msb_ext = WIDE_W'(unsigned'(idx) >> STEP_W);
    assign high    = !low && (msb_ext >= WIDE_W'(NUM_ENTRIES - 1));
    assign frac    = (low || high) ? '0 : idx[STEP_W-1:0];

    // left and right entry addresses; clamped lookups read one entry twice
    always_comb begin
        if (low) begin
            addr_a = '0;
            addr_b = '0;
        end else if (high) begin
            addr_a = ADDR_W'(NUM_ENTRIES - 1);
            addr_b = ADDR_W'(NUM_ENTRIES - 1);
        end else begin
            addr_a = msb_ext[ADDR_W-1:0];
            addr_b = msb_ext[ADDR_W-1:0] + ADDR_W'(1);
        end
    end

    // entry writes beyond the table are dropped
    assign wr_idx_ext = WIDE_W'(s_entry_index);
    assign wr_en      = s_fire && (s_cmd == CMD_WRITE)
                        && (wr_idx_ext < WIDE_W'(NUM_ENTRIES));

    gtoi_offset_table #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .ADDR_W      (ADDR_W)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_idx_ext[ADDR_W-1:0]),
        .wr_data   ({s_entry_z, s_entry_y, s_entry_x}),
        .rd_en     (lookup_fire),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // read stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (lookup_fire) begin
            s1_vld_reg <= 1'b1;
        end else if (out_free) begin
            s1_vld_reg <= 1'b0;
        end
    end

    // read stage payload
    always_ff @(posedge aclk) begin
        if (lookup_fire) begin
            s1_low_reg  <= low;
            s1_high_reg <= high;
            s1_frac_reg <= frac;
        end
    end

    assign s1_interp = !s1_low_reg && !s1_high_reg;

    // per-axis interpolation
    gtoi_interp_axis u_axis_x (
        .left_val    (rd_a[DATA_W-1:0]),
        .right_val   (rd_b[DATA_W-1:0]),
        .frac        (s1_frac_reg),
        .interp      (s1_interp),
        .residual    (cfg.residual_x),
        .coupling    (cfg.coupling_x),
        .offset      (off_x),
        .rate_offset (rate_x)
    );

    gtoi_interp_axis u_axis_y (
        .left_val    (rd_a[2*DATA_W-1:DATA_W]),
        .right_val   (rd_b[2*DATA_W-1:DATA_W]),
        .frac        (s1_frac_reg),
        .interp      (s1_interp),
        .residual    (cfg.residual_y),
        .coupling    (cfg.coupling_y),
        .offset      (off_y),
        .rate_offset (rate_y)
    );

    gtoi_interp_axis u_axis_z (
        .left_val    (rd_a[3*DATA_W-1:2*DATA_W]),
        .right_val   (rd_b[3*DATA_W-1:2*DATA_W]),
        .frac        (s1_frac_reg),
        .interp      (s1_interp),
        .residual    (cfg.residual_z),
        .coupling    (cfg.coupling_z),
        .offset      (off_z),
        .rate_offset (rate_z)
    );

    // result register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_vld_reg;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (out_free && s1_vld_reg) begin
            off_x_reg  <= off_x;
            off_y_reg  <= off_y;
            off_z_reg  <= off_z;
            rate_x_reg <= rate_x;
            rate_y_reg <= rate_y;
            rate_z_reg <= rate_z;
            low_reg    <= s1_low_reg;
            high_reg   <= s1_high_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_offset_x      = off_x_reg;
    assign m_offset_y      = off_y_reg;
    assign m_offset_z      = off_z_reg;
    assign m_rate_offset_x = rate_x_reg;
    assign m_rate_offset_y = rate_y_reg;
    assign m_rate_offset_z = rate_z_reg;
    assign m_clamped_low   = low_reg;
    assign m_clamped_high  = high_reg;

endmodule

// ----- tb/gyro_temp_offset_interp_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_temp_offset_interp_core_tb
// Self-checking bench for the temperature-compensated gyro offset core.
// Fills the offset table, then drives lookups across both clamp regions and
// every interpolation interval under several register settings, with random
// gaps on the input side and random stalls on the result side. A local
// predictor computes each lookup's offsets and clamp flags; the checker
// compares every result word against them in order.
// ----------------------------------------------------------------------------
module gyro_temp_offset_interp_core_tb;
    import gtoi_pkg::*;

    localparam int TAB_DEPTH  = DEF_NUM_ENTRIES;
    localparam int IDLE_LIMIT = 2000;

    typedef logic signed [RATE_W-1:0] rate_t;

    // one expected result word
    typedef struct packed {
        axis_t ofs_x;
        axis_t ofs_y;
        axis_t ofs_z;
        rate_t rate_x;
        rate_t rate_y;
        rate_t rate_z;
        logic  clamp_lo;
        logic  clamp_hi;
    } offset_word_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_cmd;
    axis_t                   s_temperature;
    logic [ENTRY_IDX_W-1:0]  s_entry_index;
    axis_t                   s_entry_x;
    axis_t                   s_entry_y;
    axis_t                   s_entry_z;
    logic                    m_valid;
    logic                    m_ready;
    axis_t                   m_offset_x;
    axis_t                   m_offset_y;
    axis_t                   m_offset_z;
    rate_t                   m_rate_offset_x;
    rate_t                   m_rate_offset_y;
    rate_t                   m_rate_offset_z;
    logic                    m_clamped_low;
    logic                    m_clamped_high;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [DATA_W-1:0]       cfg_data;

    // predictor state: offset table and register copies
    axis_t offset_tab [TAB_DEPTH][3];
    axis_t cal_origin;
    axis_t cal_resid [3];
    axis_t cal_coupl [3];

    offset_word_t expected_offsets [$];
    offset_word_t want;

    bit steady;
    int errors;
    int idle_cycles;
    int n_checked;
    int n_writes;
    int n_cfg_sets;
    int n_low;
    int n_high;
    int n_interp;

    gyro_temp_offset_interp_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_temperature   (s_temperature),
        .s_entry_index   (s_entry_index),
        .s_entry_x       (s_entry_x),
        .s_entry_y       (s_entry_y),
        .s_entry_z       (s_entry_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_offset_x      (m_offset_x),
        .m_offset_y      (m_offset_y),
        .m_offset_z      (m_offset_z),
        .m_rate_offset_x (m_rate_offset_x),
        .m_rate_offset_y (m_rate_offset_y),
        .m_rate_offset_z (m_rate_offset_z),
        .m_clamped_low   (m_clamped_low),
        .m_clamped_high  (m_clamped_high),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // offsets for one temperature reading, from the current table and registers
    function automatic offset_word_t predict_offsets(axis_t temp);
        offset_word_t w;
        int    span;
        int    seg;
        int    frac;
        int    left;
        int    diff;
        axis_t sum [3];
        span = int'(temp) - int'(cal_origin);
        seg  = span / TEMP_STEP;
        frac = span % TEMP_STEP;
        w.clamp_lo = (span < 0);
        w.clamp_hi = (span >= 0) && (seg >= TAB_DEPTH - 1);
        for (int a = 0; a < 3; a++) begin
            if (w.clamp_lo) begin
                sum[a] = axis_t'(int'(cal_resid[a]) + int'(offset_tab[0][a]));
            end else if (w.clamp_hi) begin
                sum[a] = axis_t'(int'(cal_resid[a]) + int'(offset_tab[TAB_DEPTH-1][a]));
            end else begin
                left   = offset_tab[seg][a];
                diff   = int'(offset_tab[seg+1][a]) - left;
                // signed division truncates toward zero
                sum[a] = axis_t'(int'(cal_coupl[a]) + int'(cal_resid[a]) + left
                                 + (diff * frac) / TEMP_STEP);
            end
        end
        w.ofs_x  = sum[0];
        w.ofs_y  = sum[1];
        w.ofs_z  = sum[2];
        w.rate_x = sum[0][DATA_W-1:RATE_SHIFT];
        w.rate_y = sum[1][DATA_W-1:RATE_SHIFT];
        w.rate_z = sum[2][DATA_W-1:RATE_SHIFT];
        return w;
    endfunction

    // random field value, biased toward the extremes
    function automatic axis_t pick_value();
        case ($urandom_range(0, 7))
            0: return axis_t'(32767);
            1: return axis_t'(-32768);
            2: return axis_t'(0);
            3: return axis_t'(-1);
            default: return axis_t'($urandom);
        endcase
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            errors++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_val, act_val);
        end
    endfunction

    // send one input word, with an optional gap before it
    task automatic send_word(logic cmd, axis_t temp, logic [ENTRY_IDX_W-1:0] ent,
                             axis_t x, axis_t y, axis_t z);
        offset_word_t w;
        @(negedge aclk);
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_temperature <= temp;
        s_entry_index <= ent;
        s_entry_x     <= x;
        s_entry_y     <= y;
        s_entry_z     <= z;
        do @(posedge aclk); while (!s_ready);
        // update the predictor at the accepting edge
        if (cmd == CMD_WRITE) begin
            offset_tab[ent][0] = x;
            offset_tab[ent][1] = y;
            offset_tab[ent][2] = z;
            n_writes++;
        end else begin
            w = predict_offsets(temp);
            if (w.clamp_lo) n_low++;
            else if (w.clamp_hi) n_high++;
            else n_interp++;
            expected_offsets.push_back(w);
        end
    endtask

    task automatic lookup(axis_t temp);
        send_word(CMD_LOOKUP, temp, ENTRY_IDX_W'($urandom), axis_t'($urandom),
                  axis_t'($urandom), axis_t'($urandom));
    endtask

    task automatic send_random_word();
        int span;
        if ($urandom_range(0, 4) == 0) begin
            send_word(CMD_WRITE, axis_t'($urandom), ENTRY_IDX_W'($urandom),
                      pick_value(), pick_value(), pick_value());
        end else if ($urandom_range(0, 6) == 0) begin
            lookup(axis_t'($urandom));
        end else begin
            // mostly near the table span, including both clamp regions
            span = int'(cal_origin) - 2 * TEMP_STEP
                   + int'($urandom_range(0, (TAB_DEPTH + 3) * TEMP_STEP));
            if (span < -32768 || span > 32767) lookup(axis_t'($urandom));
            else lookup(axis_t'(span));
        end
    endtask

    // wait until every expected result is back and the pipeline has emptied
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_offsets.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, axis_t val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TEMP_BASE:    cal_origin   = val;
            REG_RESIDUAL_X:   cal_resid[0] = val;
            REG_RESIDUAL_Y:   cal_resid[1] = val;
            REG_RESIDUAL_Z:   cal_resid[2] = val;
            REG_COUPLING_X:   cal_coupl[0] = val;
            REG_COUPLING_Y:   cal_coupl[1] = val;
            REG_COUPLING_Z:   cal_coupl[2] = val;
            default: ;
        endcase
    endtask

    // rewrite every register while the core is idle
    task automatic load_config(axis_t origin, axis_t rx, axis_t ry, axis_t rz,
                               axis_t cx, axis_t cy, axis_t cz);
        wait_drained();
        write_reg(REG_TEMP_BASE, origin);
        write_reg(REG_RESIDUAL_X, rx);
        write_reg(REG_RESIDUAL_Y, ry);
        write_reg(REG_RESIDUAL_Z, rz);
        write_reg(REG_COUPLING_X, cx);
        write_reg(REG_COUPLING_Y, cy);
        write_reg(REG_COUPLING_Z, cz);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        n_cfg_sets++;
    endtask

    // fill the whole table, then probe interval edges with reset registers
    task automatic test_table_edges();
        send_word(CMD_WRITE, axis_t'($urandom), 4'd0, axis_t'(-32768), axis_t'(32767), 16'sd0);
        send_word(CMD_WRITE, axis_t'($urandom), 4'd1, axis_t'(32767), axis_t'(-32768), 16'sd1);
        send_word(CMD_WRITE, axis_t'($urandom), 4'd2, axis_t'(-32768), axis_t'(32767), -16'sd1);
        for (int e = 3; e < TAB_DEPTH; e++) begin
            send_word(CMD_WRITE, axis_t'($urandom), ENTRY_IDX_W'(e),
                      pick_value(), pick_value(), pick_value());
        end
        lookup(axis_t'(-32768));                          // far below origin
        lookup(axis_t'(-1));                              // just below origin
        lookup(axis_t'(0));                               // exactly on entry 0
        lookup(axis_t'(TEMP_STEP - 1));                   // largest fraction, rising
        lookup(axis_t'(TEMP_STEP + 1));                   // falling, truncation toward zero
        lookup(axis_t'((TAB_DEPTH - 1) * TEMP_STEP - 1)); // end of last interval
        lookup(axis_t'((TAB_DEPTH - 1) * TEMP_STEP));     // first high clamp
        lookup(axis_t'(32767));                           // far above
    endtask

    // register extremes, with sums that wrap
    task automatic test_config_extremes();
        load_config(axis_t'(-32768), axis_t'(32767), axis_t'(-32768), 16'sd0,
                    axis_t'(32767), axis_t'(-32768), 16'sd1);
        repeat (30) send_random_word();
        load_config(axis_t'(32767), axis_t'(-32768), axis_t'(32767), -16'sd1,
                    axis_t'(-32768), axis_t'(32767), -16'sd1);
        repeat (30) send_random_word();
        load_config(16'sd0, axis_t'(32767), axis_t'(32767), axis_t'(32767),
                    axis_t'(32767), axis_t'(32767), axis_t'(32767));
        repeat (30) send_random_word();
    endtask

    task automatic test_random_traffic();
        repeat (5) begin
            load_config(pick_value(), pick_value(), pick_value(), pick_value(),
                        pick_value(), pick_value(), pick_value());
            repeat (55) send_random_word();
        end
    endtask

    // closing stretch with no gaps and no stalls
    task automatic test_back_to_back();
        steady = 1'b1;
        load_config(axis_t'($urandom_range(0, 2000) - 1000), pick_value(), pick_value(),
                    pick_value(), pick_value(), pick_value(), pick_value());
        repeat (60) send_random_word();
    endtask

    // result side stalls
    always begin
        @(negedge aclk);
        if (steady) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
        end else begin
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 24)) @(negedge aclk);
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_offsets.size() == 0) begin
                errors++;
                $display("%0t ns: result word with none expected, offset_x actual %0d",
                         $time, m_offset_x);
            end else begin
                want = expected_offsets.pop_front();
                check_field("offset_x", int'(want.ofs_x), int'(m_offset_x));
                check_field("offset_y", int'(want.ofs_y), int'(m_offset_y));
                check_field("offset_z", int'(want.ofs_z), int'(m_offset_z));
                check_field("rate_offset_x", int'(want.rate_x), int'(m_rate_offset_x));
                check_field("rate_offset_y", int'(want.rate_y), int'(m_rate_offset_y));
                check_field("rate_offset_z", int'(want.rate_z), int'(m_rate_offset_z));
                check_field("clamped_low", int'(want.clamp_lo), int'(m_clamped_low));
                check_field("clamped_high", int'(want.clamp_hi), int'(m_clamped_high));
                n_checked++;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // main sequence
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_cmd         = CMD_LOOKUP;
        s_temperature = '0;
        s_entry_index = '0;
        s_entry_x     = '0;
        s_entry_y     = '0;
        s_entry_z     = '0;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_TEMP_BASE;
        cfg_data      = '0;
        steady        = 1'b0;
        errors        = 0;
        idle_cycles   = 0;
        n_checked     = 0;
        n_writes      = 0;
        n_cfg_sets    = 0;
        n_low         = 0;
        n_high        = 0;
        n_interp      = 0;
        cal_origin    = '0;
        for (int a = 0; a < 3; a++) begin
            cal_resid[a] = '0;
            cal_coupl[a] = '0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_table_edges();
        test_config_extremes();
        test_random_traffic();
        test_back_to_back();
        wait_drained();

        $display("covered %0d table writes and %0d checked lookups over %0d register sets",
                 n_writes, n_checked, n_cfg_sets);
        $display("lookups: %0d clamped low, %0d clamped high, %0d interpolated",
                 n_low, n_high, n_interp);
        if (errors == 0 && expected_offsets.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/gtoi_pkg.sv
design/gtoi_cfg_regs.sv
design/gtoi_offset_table.sv
design/gtoi_interp_axis.sv
design/gyro_temp_offset_interp_core.sv
tb/gyro_temp_offset_interp_core_tb.sv
